// ===== hw/rtl/deadline_timer_manager_macros.svh =====
// ----------------------------------------------------------------------------
// deadline timer manager assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_MANAGER_MACROS_SVH
`define DEADLINE_TIMER_MANAGER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define DTM_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define DTM_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// dtm_pkg
// types, codes and helpers shared by the timer cells and the controller
// ----------------------------------------------------------------------------
`default_nettype none

package dtm_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int ID_W        = 4;
    localparam int TMO_W       = 31;
    localparam int TIME_W      = 32;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 8;

    localparam logic [TIME_W-1:0] SIGN_BIT = 32'h8000_0000;

    // input action codes
    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [TIME_W-1:0] t_time;

    // slot update commands broadcast to the cells
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET,
        OP_CLEAR,
        OP_MOVE,
        OP_DISARM
    } t_op;

    typedef struct packed {
        t_op   op;
        t_slot idx;
        t_time target;
    } t_cmd;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  pend;
        t_time key;
        t_slot idx;
    } t_bid;

    // a is strictly later than b on the wrapping clock
    function automatic logic is_later(input t_time a, input t_time b);
        t_time d;
        d = a - b;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    // biased key at or below the sign bit means the deadline is reached
    function automatic logic key_reached(input t_time key);
        return !key[TIME_W-1] || (key == SIGN_BIT);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dtm_cell.sv =====
// ----------------------------------------------------------------------------
// dtm_cell
// one timer slot: armed and pending deadlines plus one stage of the min search
// ----------------------------------------------------------------------------
`default_nettype none

module dtm_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dtm_pkg::t_slot i_index,
    input  wire dtm_pkg::t_time i_now,
    input  wire dtm_pkg::t_cmd  i_cmd,
    input  wire logic           i_go,
    input  wire dtm_pkg::t_bid  i_bid,
    output logic                o_go,
    output dtm_pkg::t_bid       o_bid
);

    logic           r_armed;
    logic           r_pending;
    dtm_pkg::t_time r_deadline;
    dtm_pkg::t_time r_pdl;
    logic           r_go;
    dtm_pkg::t_bid  r_bid;

    logic           n_armed;
    logic           n_pending;
    dtm_pkg::t_time n_deadline;
    dtm_pkg::t_time n_pdl;
    dtm_pkg::t_bid  n_bid;

    logic           w_hit;
    logic           w_take;
    dtm_pkg::t_time w_key;

    assign w_hit  = (i_cmd.idx == i_index);
    assign w_key  = (r_deadline - i_now) ^ dtm_pkg::SIGN_BIT;
    // strict compare keeps ties with the lower index upstream
    assign w_take = r_armed && (!i_bid.valid || (w_key < i_bid.key));

    always_comb begin
        n_armed    = r_armed;
        n_pending  = r_pending;
        n_deadline = r_deadline;
        n_pdl      = r_pdl;
        if (w_hit) begin
            unique case (i_cmd.op)
                dtm_pkg::OP_SET: begin
                    if (r_armed && dtm_pkg::is_later(i_cmd.target, r_deadline)) begin
                        n_pdl     = i_cmd.target;
                        n_pending = 1'b1;
                    end else begin
                        n_deadline = i_cmd.target;
                        n_armed    = 1'b1;
                        n_pending  = 1'b0;
                    end
                end
                dtm_pkg::OP_CLEAR: begin
                    n_armed   = 1'b0;
                    n_pending = 1'b0;
                end
                dtm_pkg::OP_MOVE: begin
                    n_deadline = r_pdl;
                    n_pending  = 1'b0;
                end
                dtm_pkg::OP_DISARM: begin
                    n_armed = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_bid = i_bid;
        if (w_take) begin
            n_bid.valid = 1'b1;
            n_bid.pend  = r_pending;
            n_bid.key   = w_key;
            n_bid.idx   = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_pending <= 1'b0;
            r_go      <= 1'b0;
        end else begin
            r_armed   <= n_armed;
            r_pending <= n_pending;
            r_go      <= i_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deadline <= n_deadline;
        r_pdl      <= n_pdl;
        r_bid      <= n_bid;
    end

    assign o_go  = r_go;
    assign o_bid = r_bid;

endmodule

`default_nettype wire

// ===== hw/rtl/deadline_timer_manager.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_manager
// bank of one-shot millisecond timers with deferred rearm
//
// input stream (s side): one transaction per command; set, cancel or tick.
// set and cancel are taken while idle and give no output. a tick bumps the
// clock and then scans the slots: a search token walks the row of timer cells,
// one cell per cycle. each pass either fires the earliest reached slot, disarms
// it without output once the result cap is reached, or moves it to its pending
// deadline, and the last pass finds nothing reached.
// output stream (m side): one transaction per fired slot, in deadline order,
// tlast on the final one of the tick. one result is held back so tlast can be
// set; the output register lets the next command in while a result waits.
// a stalled receiver holds the scan when a firing finds the output register
// still full, and holds the end of the tick until the last result moves in.
// reset clears the clock and all armed and pending flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deadline_timer_manager_macros.svh"

module deadline_timer_manager (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side: [1:0] action, [5:2] timer_id, [36:6] timeout_ms, [39:37] zero
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [dtm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // master side: [3:0] fired_timer, [7:4] zero
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [dtm_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } t_state;

    // input field split
    logic [1:0]                  w_action;
    dtm_pkg::t_id                w_id;
    logic [dtm_pkg::TMO_W-1:0]   w_tmo;
    logic                        w_in_range;

    assign w_action   = i_s_tdata[1:0];
    assign w_id       = i_s_tdata[5:2];
    assign w_tmo      = i_s_tdata[36:6];
    assign w_in_range = (32'(w_id) < dtm_pkg::TIMER_SLOTS);

    // controller registers
    t_state                      r_state, n_state;
    dtm_pkg::t_time              r_now, n_now;
    dtm_pkg::t_cmd               r_cmd, n_cmd;
    logic                        r_inject, n_inject;
    dtm_pkg::t_bid               r_best, n_best;
    logic                        r_hold_valid, n_hold_valid;
    dtm_pkg::t_slot              r_hold_idx, n_hold_idx;
    logic [dtm_pkg::CNT_W-1:0]   r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    dtm_pkg::t_slot              r_out_idx, n_out_idx;
    logic                        r_out_last, n_out_last;

    // cell row links: index 0 feeds the first cell, the top one leaves the row
    logic [dtm_pkg::TIMER_SLOTS:0] w_go;
    dtm_pkg::t_bid                 w_bid [dtm_pkg::TIMER_SLOTS+1];

    logic w_out_free;
    logic w_end_reached;

    assign w_go[0]       = r_inject;
    assign w_bid[0]      = '0;
    assign w_out_free    = !r_out_valid || i_m_tready;
    assign w_end_reached = w_bid[dtm_pkg::TIMER_SLOTS].valid
                           && dtm_pkg::key_reached(w_bid[dtm_pkg::TIMER_SLOTS].key);

    for (genvar g = 0; g < dtm_pkg::TIMER_SLOTS; g++) begin : g_cell
        dtm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (dtm_pkg::t_slot'(g)),
            .i_now   (r_now),
            .i_cmd   (r_cmd),
            .i_go    (w_go[g]),
            .i_bid   (w_bid[g]),
            .o_go    (w_go[g+1]),
            .o_bid   (w_bid[g+1])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_cmd        = r_cmd;
        n_cmd.op     = dtm_pkg::OP_NONE;
        n_inject     = (r_state == ST_START);
        n_best       = r_best;
        n_hold_valid = r_hold_valid;
        n_hold_idx   = r_hold_idx;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;

        // result taken by the receiver
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (w_action)
                        dtm_pkg::ACT_SET: begin
                            if (w_in_range) begin
                                n_cmd.idx    = dtm_pkg::t_slot'(w_id);
                                n_cmd.target = r_now + {1'b0, w_tmo};
                                // zero timeout acts as cancel
                                n_cmd.op     = (w_tmo == '0) ? dtm_pkg::OP_CLEAR
                                                             : dtm_pkg::OP_SET;
                            end
                        end
                        dtm_pkg::ACT_CANCEL: begin
                            if (w_in_range) begin
                                n_cmd.idx = dtm_pkg::t_slot'(w_id);
                                n_cmd.op  = dtm_pkg::OP_CLEAR;
                            end
                        end
                        dtm_pkg::ACT_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_count = '0;
                            n_state = ST_START;
                        end
                        default: begin
                            // unused action code, dropped
                        end
                    endcase
                end
            end
            ST_START: begin
                // slot command lands this cycle, token enters the row next
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_go[dtm_pkg::TIMER_SLOTS]) begin
                    n_best  = w_bid[dtm_pkg::TIMER_SLOTS];
                    n_state = w_end_reached ? ST_DECIDE : ST_FLUSH;
                end
            end
            ST_DECIDE: begin
                n_cmd.idx = r_best.idx;
                if (r_best.pend) begin
                    // deferred rearm instead of firing
                    n_cmd.op = dtm_pkg::OP_MOVE;
                    n_state  = ST_START;
                end else if (r_count == dtm_pkg::CNT_W'(dtm_pkg::MAX_RESULTS)) begin
                    // result cap reached, slot still expires silently
                    n_cmd.op = dtm_pkg::OP_DISARM;
                    n_state  = ST_START;
                end else if (!r_hold_valid) begin
                    n_hold_valid = 1'b1;
                    n_hold_idx   = r_best.idx;
                    n_count      = r_count + 1'b1;
                    n_cmd.op     = dtm_pkg::OP_DISARM;
                    n_state      = ST_START;
                end else if (w_out_free) begin
                    // older held result is not the last one
                    n_out_valid = 1'b1;
                    n_out_idx   = r_hold_idx;
                    n_out_last  = 1'b0;
                    n_hold_idx  = r_best.idx;
                    n_count     = r_count + 1'b1;
                    n_cmd.op    = dtm_pkg::OP_DISARM;
                    n_state     = ST_START;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_hold_idx;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_now        <= '0;
            r_cmd        <= '0;
            r_inject     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_cmd        <= n_cmd;
            r_inject     <= n_inject;
            r_best       <= n_best;
            r_hold_valid <= n_hold_valid;
            r_hold_idx   <= n_hold_idx;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_out_idx    <= n_out_idx;
            r_out_last   <= n_out_last;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(dtm_pkg::OUT_DATA_W - dtm_pkg::ID_W){1'b0}},
                         dtm_pkg::t_id'(r_out_idx)};
    assign o_m_tlast  = r_out_last;

    // search token leaves the row only while the controller waits for it
    `DTM_IMPLY(a_token_in_scan, w_go[dtm_pkg::TIMER_SLOTS], r_state == ST_SCAN,
        "search token left the cell row outside a scan")
    // never more than one search in flight along the row
    `DTM_CHECK(a_single_token, $countones(w_go) <= 1, "more than one search token in the row")
    // decisions only act on a reached armed slot
    `DTM_IMPLY(a_decide_reached, r_state == ST_DECIDE,
        r_best.valid && dtm_pkg::key_reached(r_best.key), "decision on an unreached slot")
    // result count stays within the cap
    `DTM_CHECK(a_count_cap, r_count <= dtm_pkg::CNT_W'(dtm_pkg::MAX_RESULTS),
        "result count beyond cap")

endmodule

`default_nettype wire
